/* rtl/scsa_pkg.sv */
`default_nettype none
package scsa_pkg;

	localparam int DEF_POOL_BYTES  = 1048576;
	localparam int DEF_FREE_DEPTH  = 64;
	localparam int DEF_NUM_CLASSES = 6;
	localparam int DEF_MAX_LEN     = 65535;

	localparam int ADDR_W  = 20;
	localparam int LEN_W   = 16;
	localparam int CLASS_W = 3;
	// need = length + 1, also wide enough for every class size
	localparam int SZ_W    = LEN_W + 1;

	localparam logic [CLASS_W-1:0] HUGE_CLASS = 3'd6;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	typedef struct packed {
		logic             req_type;
		logic [LEN_W-1:0] req_length;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  alloc_address;
		logic [CLASS_W-1:0] size_class;
		logic               reused_chunk;
		logic               out_of_space;
	} res_t;

	function automatic logic [SZ_W-1:0] class_size(input logic [CLASS_W-1:0] k);
		return SZ_W'(16) << k;
	endfunction

endpackage
`default_nettype wire

/* rtl/scsa_ram.sv */
`default_nettype none
module scsa_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 384,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* rtl/size_class_string_allocator.sv */
// Pop, huge, failure and clear: the result is registered in res_q on acceptance and
// then in rsp_q once the output is free. Block allocation first carves the tail in
// S_CARVE, at most one push a cycle through the single write port of the free stack RAM.
// A new request is taken only in S_IDLE, after the previous result has reached rsp_q.
// Reset (arst_n low): stack counts and bump pointer clear, no result pending;
// stack RAM contents are not cleared and need no clearing pass.
`default_nettype none
module size_class_string_allocator #(
	parameter int POOL_BYTES  = scsa_pkg::DEF_POOL_BYTES,
	parameter int FREE_DEPTH  = scsa_pkg::DEF_FREE_DEPTH,
	parameter int NUM_CLASSES = scsa_pkg::DEF_NUM_CLASSES,
	parameter int MAX_LEN     = scsa_pkg::DEF_MAX_LEN
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire scsa_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output scsa_pkg::res_t     rsp
);

	import scsa_pkg::*;

	localparam int CLS_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int CNT_W     = $clog2(FREE_DEPTH + 1);
	localparam int MEM_DEPTH = NUM_CLASSES * FREE_DEPTH;
	localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int NFB_W     = $clog2(POOL_BYTES + 1);
	localparam int SUM_W     = ((NFB_W > SZ_W) ? NFB_W : SZ_W) + 1;
	localparam logic [SZ_W-1:0] TOP = SZ_W'(16) << (NUM_CLASSES - 1);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_CARVE  = 2'd1;
	localparam logic [1:0] S_RESULT = 2'd2;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  cnt_q [NUM_CLASSES];
	logic [NFB_W-1:0]  nfb_q;
	res_t              res_q;
	logic              from_mem_q;
	logic [SZ_W-1:0]   remain_q;
	logic [ADDR_W-1:0] base_q;
	logic [CLS_W-1:0]  carve_k_q;
	logic              rsp_valid_q;
	res_t              rsp_q;

	logic              accept;
	logic [SZ_W-1:0]   need;
	logic              hit;
	logic [CLS_W-1:0]  hit_k;
	logic [CNT_W-1:0]  hit_cnt;
	logic              too_long;
	logic              is_huge;
	logic [SUM_W-1:0]  sum_need;
	logic [SUM_W-1:0]  sum_top;
	logic              rsp_free;
	res_t              res_d;
	logic              from_mem_d;
	res_t              rsp_d;

	logic [SZ_W-1:0]   carve_sz;
	logic              carve_fit;
	logic [CNT_W-1:0]  carve_cnt;

	logic              mem_we;
	logic [MEM_AW-1:0] mem_waddr;
	logic [ADDR_W-1:0] mem_wdata;
	logic              mem_re;
	logic [MEM_AW-1:0] mem_raddr;
	logic [ADDR_W-1:0] mem_rdata;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign need     = SZ_W'(req.req_length) + SZ_W'(1);
	assign too_long = 32'(req.req_length) > 32'(MAX_LEN);
	assign is_huge  = need > TOP;
	assign sum_need = SUM_W'(nfb_q) + SUM_W'(need);
	assign sum_top  = SUM_W'(nfb_q) + SUM_W'(TOP);

	// smallest non-empty class that fits
	always_comb begin
		hit     = 1'b0;
		hit_k   = '0;
		hit_cnt = '0;
		for (int i = 0; i < NUM_CLASSES; i++) begin
			if (!hit && class_size(CLASS_W'(i)) >= need && cnt_q[i] != '0) begin
				hit     = 1'b1;
				hit_k   = CLS_W'(i);
				hit_cnt = cnt_q[i];
			end
		end
	end

	always_comb begin
		res_d      = '0;
		from_mem_d = 1'b0;
		if (req.req_type == REQ_ALLOC) begin
			if (too_long) begin
				res_d.out_of_space = 1'b1;
			end else if (hit) begin
				res_d.size_class   = CLASS_W'(hit_k);
				res_d.reused_chunk = 1'b1;
				from_mem_d         = 1'b1;
			end else if (is_huge) begin
				if (sum_need > SUM_W'(POOL_BYTES)) begin
					res_d.out_of_space = 1'b1;
				end else begin
					res_d.alloc_address = ADDR_W'(nfb_q);
					res_d.size_class    = HUGE_CLASS;
				end
			end else if (sum_top > SUM_W'(POOL_BYTES)) begin
				res_d.out_of_space = 1'b1;
			end else begin
				res_d.alloc_address = ADDR_W'(nfb_q);
				res_d.size_class    = CLASS_W'(NUM_CLASSES - 1);
			end
		end
	end

	always_comb begin
		rsp_d = res_q;
		if (from_mem_q) begin
			rsp_d.alloc_address = mem_rdata;
		end
	end

	assign carve_sz  = class_size(CLASS_W'(carve_k_q));
	assign carve_fit = remain_q >= carve_sz;
	assign carve_cnt = cnt_q[carve_k_q];

	assign mem_re    = accept && req.req_type == REQ_ALLOC && !too_long && hit;
	assign mem_raddr = MEM_AW'(hit_k) * MEM_AW'(FREE_DEPTH) + MEM_AW'(hit_cnt - CNT_W'(1));
	assign mem_we    = (state_q == S_CARVE) && carve_fit && (carve_cnt < CNT_W'(FREE_DEPTH));
	assign mem_waddr = MEM_AW'(carve_k_q) * MEM_AW'(FREE_DEPTH) + MEM_AW'(carve_cnt);
	assign mem_wdata = base_q + ADDR_W'(remain_q - carve_sz);

	scsa_ram #(
		.WIDTH(ADDR_W),
		.DEPTH(MEM_DEPTH),
		.AW   (MEM_AW)
	) u_stack_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			nfb_q       <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RESULT;
						if (req.req_type == REQ_CLEAR) begin
							nfb_q <= '0;
							for (int i = 0; i < NUM_CLASSES; i++) begin
								cnt_q[i] <= '0;
							end
						end else if (too_long) begin
							state_q <= S_RESULT;
						end else if (hit) begin
							cnt_q[hit_k] <= hit_cnt - CNT_W'(1);
						end else if (is_huge) begin
							if (sum_need <= SUM_W'(POOL_BYTES)) begin
								nfb_q <= NFB_W'(sum_need);
							end
						end else if (sum_top <= SUM_W'(POOL_BYTES)) begin
							nfb_q <= NFB_W'(sum_top);
							if (NUM_CLASSES > 1) begin
								state_q <= S_CARVE;
							end
						end
					end
				end
				S_CARVE: begin
					if (mem_we) begin
						cnt_q[carve_k_q] <= carve_cnt + CNT_W'(1);
					end
					if (carve_k_q == '0) begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (state_q == S_RESULT && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q      <= res_d;
			from_mem_q <= from_mem_d;
			remain_q   <= TOP - need;
			base_q     <= ADDR_W'(sum_need);
			carve_k_q  <= CLS_W'(NUM_CLASSES - 2);
		end
		if (state_q == S_CARVE) begin
			if (carve_fit) begin
				remain_q <= remain_q - carve_sz;
			end
			carve_k_q <= carve_k_q - CLS_W'(1);
		end
		if (state_q == S_RESULT && rsp_free) begin
			rsp_q <= rsp_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == S_CARVE)
		else $error("stack write outside carving");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.req_type == REQ_CLEAR |=> nfb_q == '0)
		else $error("clear did not reset bump pointer");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.out_of_space |->
			rsp.alloc_address == '0 && rsp.size_class == '0 && !rsp.reused_chunk)
		else $error("failed allocation carries payload");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.reused_chunk |-> rsp.size_class < CLASS_W'(NUM_CLASSES))
		else $error("reused chunk from nonexistent class");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("accepted transaction not processed");

endmodule
`default_nettype wire

/* verif/scsa_checker.sv */
module scsa_checker #(
	parameter int POOL_BYTES  = scsa_pkg::DEF_POOL_BYTES,
	parameter int FREE_DEPTH  = scsa_pkg::DEF_FREE_DEPTH,
	parameter int NUM_CLASSES = scsa_pkg::DEF_NUM_CLASSES,
	parameter int MAX_LEN     = scsa_pkg::DEF_MAX_LEN
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	input  wire logic           req_stall,
	input  wire scsa_pkg::req_t req,
	input  wire logic           rsp_valid,
	input  wire logic           rsp_stall,
	input  wire scsa_pkg::res_t rsp,
	output int                  n_fail,
	output int                  n_pending,
	output int                  n_checked,
	output int                  n_reused,
	output int                  n_no_space,
	output int                  n_dropped
);

	import scsa_pkg::*;

	localparam int BLOCK_BYTES = 16 << (NUM_CLASSES - 1);

	logic [ADDR_W-1:0] free_chunks [NUM_CLASSES][FREE_DEPTH];
	int                chunk_count [NUM_CLASSES] = '{default: 0};
	int                bump_ptr = 0;
	res_t              pending_results [$];

	initial begin
		n_fail     = 0;
		n_pending  = 0;
		n_checked  = 0;
		n_reused   = 0;
		n_no_space = 0;
		n_dropped  = 0;
	end

	function automatic res_t serve_request(input req_t r);
		res_t o;
		int   need;
		int   base;
		int   tail;
		int   sz;
		int   k;
		o = '0;
		if (r.req_type == REQ_CLEAR) begin
			for (k = 0; k < NUM_CLASSES; k++)
				chunk_count[k] = 0;
			bump_ptr = 0;
			return o;
		end
		need = int'(r.req_length) + 1;
		if (int'(r.req_length) > MAX_LEN) begin
			o.out_of_space = 1'b1;
			n_no_space++;
			return o;
		end
		// smallest non-empty class that holds the string wins
		for (k = 0; k < NUM_CLASSES; k++) begin
			if ((16 << k) >= need && chunk_count[k] > 0) begin
				chunk_count[k]--;
				o.alloc_address = free_chunks[k][chunk_count[k]];
				o.size_class    = CLASS_W'(k);
				o.reused_chunk  = 1'b1;
				n_reused++;
				return o;
			end
		end
		if (need > BLOCK_BYTES) begin
			if (bump_ptr + need > POOL_BYTES) begin
				o.out_of_space = 1'b1;
				n_no_space++;
				return o;
			end
			o.alloc_address = ADDR_W'(bump_ptr);
			o.size_class    = HUGE_CLASS;
			bump_ptr += need;
			return o;
		end
		if (bump_ptr + BLOCK_BYTES > POOL_BYTES) begin
			o.out_of_space = 1'b1;
			n_no_space++;
			return o;
		end
		o.alloc_address = ADDR_W'(bump_ptr);
		o.size_class    = CLASS_W'(NUM_CLASSES - 1);
		base = bump_ptr + need;
		tail = BLOCK_BYTES - need;
		bump_ptr += BLOCK_BYTES;
		// carve the tail from its end, largest class first; drop on a full stack
		for (k = NUM_CLASSES - 1; k >= 0; k--) begin
			sz = 16 << k;
			if (tail >= sz) begin
				if (chunk_count[k] < FREE_DEPTH) begin
					free_chunks[k][chunk_count[k]] = ADDR_W'(base + tail - sz);
					chunk_count[k]++;
				end else begin
					n_dropped++;
				end
				tail -= sz;
			end
		end
		return o;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_fail++;
		end
	endtask

	task automatic check_result(input res_t got);
		res_t want;
		if (pending_results.size() == 0) begin
			$error("result transaction with no request outstanding: %p", got);
			n_fail++;
		end else begin
			want = pending_results.pop_front();
			compare_field("alloc_address", want.alloc_address, got.alloc_address);
			compare_field("size_class", want.size_class, got.size_class);
			compare_field("reused_chunk", want.reused_chunk, got.reused_chunk);
			compare_field("out_of_space", want.out_of_space, got.out_of_space);
			n_checked++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				pending_results.push_back(serve_request(req));
			if (rsp_valid && !rsp_stall)
				check_result(rsp);
		end
		n_pending <= pending_results.size();
	end

endmodule

/* verif/tb_top.sv */
module tb_top;
	import scsa_pkg::*;

	typedef enum int {
		LEN_SMALL,
		LEN_FILL,
		LEN_HUGE,
		LEN_ANY
	} len_mix_e;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	res_t rsp;

	bit   quiet    = 1'b0;
	int   rsp_wait = 0;
	int   n_sent   = 0;
	int   n_clears = 0;
	int   n_fail;
	int   n_pending;
	int   n_checked;
	int   n_reused;
	int   n_no_space;
	int   n_dropped;

	always #5 clk = ~clk;

	size_class_string_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	scsa_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.n_fail     (n_fail),
		.n_pending  (n_pending),
		.n_checked  (n_checked),
		.n_reused   (n_reused),
		.n_no_space (n_no_space),
		.n_dropped  (n_dropped)
	);

	// after each accepted result, hold stall for a random number of cycles
	always @(posedge clk) begin : rsp_side
		int n;
		if (rsp_valid && !rsp_stall) begin
			n = quiet ? 0 : $urandom_range(0, 15);
			rsp_wait  <= n;
			rsp_stall <= (n != 0);
		end else if (rsp_wait > 1) begin
			rsp_wait <= rsp_wait - 1;
		end else begin
			rsp_wait  <= 0;
			rsp_stall <= 1'b0;
		end
	end

	task automatic send_req(input logic kind, input int len);
		req_t r;
		int   gap;
		r.req_type   = kind;
		r.req_length = LEN_W'(len);
		gap = quiet ? 0 : $urandom_range(0, 15);
		repeat (gap) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		n_sent++;
		if (kind == REQ_CLEAR)
			n_clears++;
	endtask

	function automatic int pick_length(input len_mix_e mix);
		case (mix)
			LEN_SMALL: return $urandom_range(0, (16 << $urandom_range(0, 4)) - 1);
			// need of 257..512 takes a whole block, carves the tail into smaller classes and never pops
			LEN_FILL:  return $urandom_range(256, 511);
			LEN_HUGE:  return ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(512, 65535);
			default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
				: $urandom_range(0, 511);
		endcase
	endfunction

	initial begin
		len_mix_e mix;
		int       span;
		int       n_random;
		n_random = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fresh block, pops of classes 0, 1, 2 and 4, block edges, huge, then exhaust the pool
		send_req(REQ_CLEAR, 16'hFFFF);
		send_req(REQ_ALLOC, 0);
		send_req(REQ_ALLOC, 0);
		send_req(REQ_ALLOC, 15);
		send_req(REQ_ALLOC, 16);
		send_req(REQ_ALLOC, 255);
		send_req(REQ_ALLOC, 256);
		send_req(REQ_ALLOC, 511);
		send_req(REQ_ALLOC, 512);
		repeat (16)
			send_req(REQ_ALLOC, 65535);
		send_req(REQ_CLEAR, 0);
		send_req(REQ_ALLOC, 65535);

		while (n_random < 2000) begin
			quiet = ($urandom_range(0, 3) == 0);
			mix   = len_mix_e'($urandom_range(0, 3));
			span  = (mix == LEN_FILL) ? $urandom_range(60, 150) : $urandom_range(20, 120);
			if ($urandom_range(0, 1))
				send_req(REQ_CLEAR, $urandom_range(0, 65535));
			repeat (span) begin
				if ($urandom_range(0, 63) == 0)
					send_req(REQ_CLEAR, $urandom_range(0, 65535));
				else
					send_req(REQ_ALLOC, pick_length(mix));
				n_random++;
			end
		end
		req_valid <= 1'b0;

		// let the last acceptance reach the pending count before polling it
		@(posedge clk);
		while (n_pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("sent %0d requests including %0d pool clears; %0d results compared",
			n_sent, n_clears, n_checked);
		$display("reused chunks %0d, out-of-space answers %0d, chunks dropped on full stacks %0d",
			n_reused, n_no_space, n_dropped);
		if (n_fail == 0 && n_pending == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule

/* filelist.f */
rtl/scsa_pkg.sv
rtl/scsa_ram.sv
rtl/size_class_string_allocator.sv
verif/scsa_checker.sv
verif/tb_top.sv
